// ===== hw/rtl/cts_pkg.sv =====
// Shared types, codes and microcode ROM for the cooperative task scheduler.
`timescale 1ns / 1ps
package cts_pkg;

  localparam int MAX_TASKS_DEF = 16;
  localparam int TICK_MS_DEF   = 10;
  localparam int RESULT_CAP    = 16;
  localparam logic [7:0] PENDING_MAX = 8'd255;

  // Command opcodes
  localparam logic [1:0] OP_ADD  = 2'd0;
  localparam logic [1:0] OP_TICK = 2'd1;
  localparam logic [1:0] OP_DISP = 2'd2;
  localparam logic [1:0] OP_DEL  = 2'd3;

  // Response kinds
  localparam logic [1:0] KIND_ADDED = 2'd0;
  localparam logic [1:0] KIND_FULL  = 2'd1;
  localparam logic [1:0] KIND_RUN   = 2'd2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] delay_ms;
    logic [31:0] period_ms;
    logic [3:0]  task_index;
  } cmd_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] task_id;
    logic       last;
  } rsp_t;

  typedef struct packed {
    logic [31:0] delay;
    logic [31:0] period;
    logic [7:0]  pending;
  } slot_rec_t;

  // Datapath operations
  localparam logic [3:0] DP_IDLE     = 4'd0;
  localparam logic [3:0] DP_ADD_CHK  = 4'd1;
  localparam logic [3:0] DP_DIV      = 4'd2;
  localparam logic [3:0] DP_ADD_WR   = 4'd3;
  localparam logic [3:0] DP_ADD_FULL = 4'd4;
  localparam logic [3:0] DP_TICK     = 4'd5;
  localparam logic [3:0] DP_DISP     = 4'd6;
  localparam logic [3:0] DP_DISP_END = 4'd7;
  localparam logic [3:0] DP_DEL      = 4'd8;

  // Branch conditions
  localparam logic [2:0] C_NEXT = 3'd0;  // fall through
  localparam logic [2:0] C_GOTO = 3'd1;  // jump always
  localparam logic [2:0] C_OPC  = 3'd2;  // wait for command, jump by opcode
  localparam logic [2:0] C_FULL = 3'd3;  // jump if table full
  localparam logic [2:0] C_DIV  = 3'd4;  // repeat until divide done
  localparam logic [2:0] C_SCAN = 3'd5;  // repeat until scan ends, then jump

  // Microcode addresses
  localparam logic [3:0] U_IDLE     = 4'd0;
  localparam logic [3:0] U_ADD_CHK  = 4'd1;
  localparam logic [3:0] U_DIV      = 4'd2;
  localparam logic [3:0] U_ADD_WR   = 4'd3;
  localparam logic [3:0] U_ADD_FULL = 4'd4;
  localparam logic [3:0] U_TICK     = 4'd5;
  localparam logic [3:0] U_DISP     = 4'd6;
  localparam logic [3:0] U_DISP_END = 4'd7;
  localparam logic [3:0] U_DEL      = 4'd8;

  typedef struct packed {
    logic [3:0] op;
    logic [2:0] cond;
    logic [3:0] target;
  } uword_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] opcode;
    logic       full;
    logic       div_done;
    logic       scan_end;
    logic       hold;
  } status_t;

  function automatic uword_t ucode_rom(input logic [3:0] pc);
    uword_t w;
    unique case (pc)
      U_IDLE:     w = '{op: DP_IDLE,     cond: C_OPC,  target: U_IDLE};
      U_ADD_CHK:  w = '{op: DP_ADD_CHK,  cond: C_FULL, target: U_ADD_FULL};
      U_DIV:      w = '{op: DP_DIV,      cond: C_DIV,  target: U_DIV};
      U_ADD_WR:   w = '{op: DP_ADD_WR,   cond: C_GOTO, target: U_IDLE};
      U_ADD_FULL: w = '{op: DP_ADD_FULL, cond: C_GOTO, target: U_IDLE};
      U_TICK:     w = '{op: DP_TICK,     cond: C_SCAN, target: U_IDLE};
      U_DISP:     w = '{op: DP_DISP,     cond: C_SCAN, target: U_DISP_END};
      U_DISP_END: w = '{op: DP_DISP_END, cond: C_GOTO, target: U_IDLE};
      U_DEL:      w = '{op: DP_DEL,      cond: C_GOTO, target: U_IDLE};
      default:    w = '{op: DP_IDLE,     cond: C_GOTO, target: U_IDLE};
    endcase
    return w;
  endfunction

  function automatic logic [3:0] op_entry(input logic [1:0] opcode);
    logic [3:0] a;
    unique case (opcode)
      OP_ADD:  a = U_ADD_CHK;
      OP_TICK: a = U_TICK;
      OP_DISP: a = U_DISP;
      OP_DEL:  a = U_DEL;
    endcase
    return a;
  endfunction

endpackage

// ===== hw/rtl/cts_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
module cts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/cts_div.sv =====
// Reciprocal-multiply lane: divides by a fixed tick length in two steps.
`timescale 1ns / 1ps
module cts_div #(
  parameter int TICK_MS = 10
) (
  input  logic        clk,
  input  logic        start,
  input  logic        step,
  input  logic [31:0] dividend,
  output logic [31:0] quotient
);

  // q = (n * RECIP) >> (32 + L) with RECIP = ceil(2^(32+L) / TICK_MS) is exact
  // for every 32-bit n; RECIP needs 33 bits.
  localparam int L  = $clog2(TICK_MS);
  localparam int AW = 66 + L;
  localparam logic [63:0] RECIP_W =
    ((64'd1 << (32 + L)) + 64'(TICK_MS) - 64'd1) / 64'(TICK_MS);
  localparam logic [32:0] RECIP = RECIP_W[32:0];

  logic [31:0]   dq;
  logic [AW-1:0] acc;
  logic          phase;
  logic [16:0]   part;
  logic [48:0]   prod;
  logic [AW-1:0] addend;

  // Low 16 reciprocal bits first, then the high 17 shifted into place.
  assign part     = phase ? RECIP[32:16] : {1'b0, RECIP[15:0]};
  assign prod     = {17'b0, dq} * {32'b0, part};
  assign addend   = phase ? (AW'(prod) << 16) : AW'(prod);
  assign quotient = acc[32+L +: 32];

  always_ff @(posedge clk) begin
    if (start) begin
      dq    <= dividend;
      acc   <= '0;
      phase <= 1'b0;
    end else if (step) begin
      acc   <= acc + addend;
      phase <= 1'b1;
    end
  end

endmodule

// ===== hw/rtl/cts_seq.sv =====
// Microcode sequencer: step counter, control ROM and branch logic.
`timescale 1ns / 1ps
module cts_seq
  import cts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  status_t status,
  output uword_t  uw,
  output logic    busy
);

  logic [3:0] upc;
  logic [3:0] upc_next;

  assign uw   = ucode_rom(upc);
  assign busy = (upc != U_IDLE);

  always_comb begin
    upc_next = upc;
    if (!status.hold) begin
      unique case (uw.cond)
        C_NEXT: upc_next = upc + 4'd1;
        C_GOTO: upc_next = uw.target;
        C_OPC:  upc_next = status.accept ? op_entry(status.opcode) : upc;
        C_FULL: upc_next = status.full ? uw.target : upc + 4'd1;
        C_DIV:  upc_next = status.div_done ? upc + 4'd1 : uw.target;
        C_SCAN: upc_next = status.scan_end ? uw.target : upc;
        default: upc_next = U_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      upc <= U_IDLE;
    end else begin
      upc <= upc_next;
    end
  end

endmodule

// ===== hw/rtl/cooperative_task_scheduler.sv =====
// Cooperative time-triggered task scheduler, microcoded over a slot table RAM.
// Add runs check, 2 multiply steps and write; tick and dispatch scan the table
// one slot per cycle; dispatch and the add write also wait out response stalls.
// A new command is taken only once the sequencer is back at its idle step.
// Reset clears control state and slot valid bits at once; the table RAM is not swept.
`timescale 1ns / 1ps
module cooperative_task_scheduler
  import cts_pkg::*;
#(
  parameter int MAX_TASKS = MAX_TASKS_DEF,
  parameter int TICK_MS   = TICK_MS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int SW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;  // slot index
  localparam int NW = $clog2(MAX_TASKS + 1);                     // fill count
  localparam int CW = $clog2(RESULT_CAP + 1);                    // results per dispatch
  localparam int XW = SW + 4;
  localparam int RECW = $bits(slot_rec_t);

  // Map a slot number onto the 4-bit task_id field (low bits only).
  function automatic logic [3:0] to_id(input logic [SW-1:0] s);
    logic [XW-1:0] x;
    x = {4'b0000, s};
    return x[3:0];
  endfunction

  uword_t  uw;
  status_t status;
  logic    busy;
  logic    accept;

  cmd_t              cmd_q;
  logic [SW-1:0]     ptr;
  logic [SW-1:0]     ptr_next;
  logic [NW-1:0]     next_free;
  logic [MAX_TASKS-1:0] slot_valid;
  logic [4:0]        div_cnt;
  logic              held_valid;
  logic [SW-1:0]     held_slot;
  logic [CW-1:0]     found_cnt;

  logic              ram_we;
  logic [SW-1:0]     ram_wa;
  slot_rec_t         ram_wd;
  logic [RECW-1:0]   ram_rdata;
  slot_rec_t         rec;

  logic [31:0]       q_delay;
  logic [31:0]       q_period;
  logic              div_start;
  logic              div_step;

  logic              full;
  logic              scan_end;
  logic              found;
  logic              hold;
  logic              out_free;
  logic              push;
  rsp_t              push_data;
  logic [SW-1:0]     nf_slot;
  logic [XW-1:0]     del_ext;
  logic [SW-1:0]     del_slot;
  logic              del_ok;

  assign accept    = cmd_valid && !cmd_stall;
  assign cmd_stall = busy;
  assign out_free  = !rsp_valid || !rsp_stall;
  assign rec       = slot_rec_t'(ram_rdata);

  assign full    = (next_free == NW'(MAX_TASKS));
  assign nf_slot = next_free[SW-1:0];
  assign del_ext = {{SW{1'b0}}, cmd_q.task_index};
  assign del_slot = del_ext[SW-1:0];
  assign del_ok  = (32'(cmd_q.task_index) < 32'(MAX_TASKS)) && slot_valid[del_slot];

  assign div_start = (uw.op == DP_ADD_CHK) && !full;
  assign div_step  = (uw.op == DP_DIV);

  // The divide takes two multiply steps.
  assign status = '{accept:   accept,
                    opcode:   cmd.opcode,
                    full:     full,
                    div_done: (div_cnt == 5'd1),
                    scan_end: scan_end,
                    hold:     hold};

  cts_seq u_seq (
    .clk    (clk),
    .rst    (rst),
    .status (status),
    .uw     (uw),
    .busy   (busy)
  );

  // One lane per stored interval; both share the step count.
  cts_div #(.TICK_MS(TICK_MS)) u_div_delay (
    .clk      (clk),
    .start    (div_start),
    .step     (div_step),
    .dividend (cmd_q.delay_ms),
    .quotient (q_delay)
  );

  cts_div #(.TICK_MS(TICK_MS)) u_div_period (
    .clk      (clk),
    .start    (div_start),
    .step     (div_step),
    .dividend (cmd_q.period_ms),
    .quotient (q_period)
  );

  // Read address runs one slot ahead so each scan step sees its own slot's data.
  cts_ram #(.WIDTH(RECW), .DEPTH(MAX_TASKS)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_wa),
    .wdata (ram_wd),
    .raddr (ptr_next),
    .rdata (ram_rdata)
  );

  // Datapath decode of the current control word.
  always_comb begin
    hold      = 1'b0;
    ram_we    = 1'b0;
    ram_wa    = ptr;
    ram_wd    = rec;
    push      = 1'b0;
    push_data = '{kind: KIND_RUN, task_id: to_id(held_slot), last: 1'b0};
    ptr_next  = ptr;
    scan_end  = 1'b0;
    found     = 1'b0;
    unique case (uw.op)
      DP_ADD_WR: begin
        // Store quotients, report the slot.
        hold      = !out_free;
        ram_we    = !hold;
        ram_wa    = nf_slot;
        ram_wd    = '{delay: q_delay, period: q_period, pending: 8'd0};
        push      = !hold;
        push_data = '{kind: KIND_ADDED, task_id: to_id(nf_slot), last: 1'b1};
      end
      DP_ADD_FULL: begin
        hold      = !out_free;
        push      = !hold;
        push_data = '{kind: KIND_FULL, task_id: 4'd0, last: 1'b1};
      end
      DP_TICK: begin
        // Count down; at zero add a run (saturating) and reload.
        scan_end = (ptr == SW'(MAX_TASKS - 1));
        ptr_next = scan_end ? '0 : ptr + SW'(1);
        ram_we   = slot_valid[ptr];
        if (rec.delay != 32'd0) begin
          ram_wd.delay = rec.delay - 32'd1;
        end else begin
          ram_wd.delay = rec.period;
          if (rec.pending != PENDING_MAX) begin
            ram_wd.pending = rec.pending + 8'd1;
          end
        end
      end
      DP_DISP: begin
        // A found run is held back until the next one is found, so the final one can carry last.
        found    = slot_valid[ptr] && (rec.pending != 8'd0);
        hold     = found && held_valid && !out_free;
        scan_end = (ptr == SW'(MAX_TASKS - 1)) ||
                   (found && (found_cnt == CW'(RESULT_CAP - 1)));
        if (!hold) begin
          ptr_next       = scan_end ? '0 : ptr + SW'(1);
          ram_we         = found;
          ram_wd.pending = rec.pending - 8'd1;
          push           = found && held_valid;
        end
      end
      DP_DISP_END: begin
        hold      = held_valid && !out_free;
        push      = held_valid && !hold;
        push_data = '{kind: KIND_RUN, task_id: to_id(held_slot), last: 1'b1};
      end
      default: begin
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      next_free  <= '0;
      slot_valid <= '0;
      div_cnt    <= '0;
      held_valid <= 1'b0;
      found_cnt  <= '0;
      rsp_valid  <= 1'b0;
    end else begin
      ptr <= ptr_next;
      if (push) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      unique case (uw.op)
        DP_IDLE: begin
          if (accept) begin
            found_cnt <= '0;
          end
        end
        DP_ADD_CHK: div_cnt <= '0;
        DP_DIV:     div_cnt <= div_cnt + 5'd1;
        DP_ADD_WR: begin
          if (!hold) begin
            slot_valid[nf_slot] <= 1'b1;
            next_free           <= next_free + NW'(1);
          end
        end
        DP_DISP: begin
          if (found && !hold) begin
            held_valid <= 1'b1;
            found_cnt  <= found_cnt + CW'(1);
            // Drop a one-shot task after its run.
            if (rec.period == 32'd0) begin
              slot_valid[ptr] <= 1'b0;
            end
          end
        end
        DP_DISP_END: begin
          if (!hold) begin
            held_valid <= 1'b0;
          end
        end
        DP_DEL: begin
          if (del_ok) begin
            slot_valid[del_slot] <= 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q <= cmd;
    end
    if (push) begin
      rsp <= push_data;
    end
    if ((uw.op == DP_DISP) && found && !hold) begin
      held_slot <= ptr;
    end
  end

endmodule

// ===== verif/cooperative_task_scheduler_tb.sv =====
// Self-checking testbench for the cooperative task scheduler: directed and random commands.
`timescale 1ns / 1ps
module cooperative_task_scheduler_tb;
  import cts_pkg::*;

  // Tick length as a 32-bit unsigned divisor, so the divide stays unsigned.
  localparam logic [31:0] TICK_LEN = TICK_MS_DEF;
  // Cycles with no transaction on either channel before the run is declared hung.
  // The slowest quiet stretch is a long sender gap while the block finishes a command.
  localparam int QUIET_LIMIT = 4000;
  // Cycles to wait after the last response.
  localparam int SETTLE_CYCLES = 60;

  logic clk;
  logic rst;
  logic cmd_valid;
  logic cmd_stall;
  cmd_t cmd;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  rsp_t rsp;

  cooperative_task_scheduler u_top (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd       (cmd),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Scheduler shadow state. It follows every accepted command and produces the
  // responses the block owes, in order, into due_responses.
  // ---------------------------------------------------------------------------
  logic        slot_live   [MAX_TASKS_DEF];
  logic [31:0] slot_ticks  [MAX_TASKS_DEF];
  logic [31:0] slot_reload [MAX_TASKS_DEF];
  logic [7:0]  slot_runs   [MAX_TASKS_DEF];
  int          next_slot;
  rsp_t        due_responses[$];

  // Run statistics for the closing summary.
  int cmds_taken;
  int adds_ok;
  int adds_full;
  int runs_due;
  int deletes_sent;
  int ceiling_hits;
  int error_count;

  // Sender burst bookkeeping.
  int burst_left;

  function automatic void clear_slot(input int s);
    slot_live[s]   = 1'b0;
    slot_ticks[s]  = '0;
    slot_reload[s] = '0;
    slot_runs[s]   = '0;
  endfunction

  // Advance the shadow state by one command and queue the responses it causes.
  task automatic apply_command(input cmd_t c);
    int used;
    int run_ids[$];
    used = (next_slot < MAX_TASKS_DEF) ? next_slot : MAX_TASKS_DEF;
    cmds_taken++;
    case (c.opcode)
      OP_ADD: begin
        if (next_slot < MAX_TASKS_DEF) begin
          slot_live[next_slot]   = 1'b1;
          slot_ticks[next_slot]  = c.delay_ms / TICK_LEN;
          slot_reload[next_slot] = c.period_ms / TICK_LEN;
          slot_runs[next_slot]   = '0;
          due_responses.push_back(rsp_t'{kind: KIND_ADDED, task_id: 4'(next_slot), last: 1'b1});
          next_slot++;
          adds_ok++;
        end else begin
          // Table full: report and change nothing.
          due_responses.push_back(rsp_t'{kind: KIND_FULL, task_id: 4'd0, last: 1'b1});
          adds_full++;
        end
      end
      OP_TICK: begin
        for (int s = 0; s < used; s++) begin
          if (slot_live[s]) begin
            if (slot_ticks[s] != 0) begin
              slot_ticks[s]--;
            end else begin
              // Saturate the run count at its top instead of wrapping.
              if (slot_runs[s] != PENDING_MAX) slot_runs[s]++;
              else ceiling_hits++;
              slot_ticks[s] = slot_reload[s];
            end
          end
        end
      end
      OP_DISP: begin
        for (int s = 0; s < used && run_ids.size() < RESULT_CAP; s++) begin
          if (slot_live[s] && slot_runs[s] != 0) begin
            slot_runs[s]--;
            run_ids.push_back(s);
            // One-shot tasks leave the table after their run.
            if (slot_reload[s] == 0) clear_slot(s);
          end
        end
        foreach (run_ids[i]) begin
          due_responses.push_back(rsp_t'{kind: KIND_RUN, task_id: 4'(run_ids[i]),
                                         last: (i == run_ids.size() - 1)});
        end
        runs_due += run_ids.size();
      end
      OP_DEL: begin
        deletes_sent++;
        // Deleting a slot that is not live is a no-op.
        if (c.task_index < MAX_TASKS_DEF && slot_live[c.task_index]) clear_slot(c.task_index);
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Command side. Inputs change on the falling edge; acceptance is judged at
  // the rising edge from the values that were stable before it.
  // ---------------------------------------------------------------------------
  function automatic cmd_t cmd_of(input logic [1:0] op, input logic [31:0] dly,
                                  input logic [31:0] per, input logic [3:0] idx);
    cmd_t c;
    c.opcode     = op;
    c.delay_ms   = dly;
    c.period_ms  = per;
    c.task_index = idx;
    return c;
  endfunction

  // Drop valid at the next falling edge and end the current burst.
  task automatic release_bus();
    if (cmd_valid) begin
      @(negedge clk);
      cmd_valid = 1'b0;
    end
    burst_left = 0;
  endtask

  // Send one command transaction. Commands go out in bursts of random length;
  // between bursts valid drops, and most of the time a random wait follows.
  task automatic send_cmd(input cmd_t c);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      repeat (gap) @(negedge clk);
    end
    @(negedge clk);
    cmd_valid = 1'b1;
    cmd       = c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    apply_command(c);
    burst_left--;
    // Hold valid only if the burst goes on; the next call drives the next edge.
    if (burst_left == 0) begin
      @(negedge clk);
      cmd_valid = 1'b0;
    end
  endtask

  // Pause the sender until every owed response has come back.
  task automatic wait_responses();
    release_bus();
    while (due_responses.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Response side: stall on a pattern that changes mode at random intervals
  // (free flow, sparse random, long runs, alternate cycles).
  // ---------------------------------------------------------------------------
  int stall_mode;
  int stall_left;

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(16, 96);
    end
    stall_left--;
    case (stall_mode)
      0: rsp_stall = 1'b0;
      1: rsp_stall = ($urandom_range(0, 3) == 0);
      2: rsp_stall = ((stall_left % 8) < 5);
      default: rsp_stall = stall_left[0];
    endcase
  end

  // Compare each accepted response with the oldest one owed.
  always @(posedge clk) begin : check_rsp
    rsp_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (due_responses.size() == 0) begin
        $error("unexpected response: kind %0d task_id %0d last %0d",
               rsp.kind, rsp.task_id, rsp.last);
        error_count++;
      end else begin
        want = due_responses.pop_front();
        if (rsp.kind !== want.kind) begin
          $error("kind: expected %0d, actual %0d", want.kind, rsp.kind);
          error_count++;
        end
        if (rsp.task_id !== want.task_id) begin
          $error("task_id: expected %0d, actual %0d", want.task_id, rsp.task_id);
          error_count++;
        end
        if (rsp.last !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, rsp.last);
          error_count++;
        end
      end
    end
  end

  // Watchdog: end the run if neither channel moves a transaction for too long.
  int quiet_cycles;

  always @(posedge clk) begin
    if ((cmd_valid && !cmd_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Add tasks at the field extremes: zero, all ones, a period below one tick; then an ordinary one.
  task automatic test_add_extremes();
    send_cmd(cmd_of(OP_ADD, 32'd0, 32'd0, 4'hF));
    send_cmd(cmd_of(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'h0));
    send_cmd(cmd_of(OP_ADD, TICK_LEN - 1, TICK_LEN - 1, 4'hA));
    send_cmd(cmd_of(OP_ADD, 32'd25, 32'd20, 4'h5));
    wait_responses();
  endtask

  // Dispatch before any tick: nothing is pending, so no response.
  task automatic test_dispatch_empty();
    send_cmd(cmd_of(OP_DISP, $urandom, $urandom, 4'($urandom)));
    wait_responses();
  endtask

  // Tick the table and dispatch; one-shot tasks run once and drop out.
  task automatic test_tick_and_run();
    send_cmd(cmd_of(OP_TICK, $urandom, $urandom, 4'($urandom)));
    send_cmd(cmd_of(OP_DISP, $urandom, $urandom, 4'($urandom)));
    repeat (3) send_cmd(cmd_of(OP_TICK, $urandom, $urandom, 4'($urandom)));
    send_cmd(cmd_of(OP_DISP, $urandom, $urandom, 4'($urandom)));
    send_cmd(cmd_of(OP_DISP, $urandom, $urandom, 4'($urandom)));
    wait_responses();
  endtask

  // Delete a live slot, the same slot again, and a slot never used.
  task automatic test_delete();
    send_cmd(cmd_of(OP_DEL, $urandom, $urandom, 4'd1));
    send_cmd(cmd_of(OP_DEL, $urandom, $urandom, 4'd1));
    send_cmd(cmd_of(OP_DEL, $urandom, $urandom, 4'd15));
    send_cmd(cmd_of(OP_TICK, $urandom, $urandom, 4'($urandom)));
    send_cmd(cmd_of(OP_DISP, $urandom, $urandom, 4'($urandom)));
    wait_responses();
  endtask

  // Mostly ticks and dispatches over tasks with short periods, some adds and
  // a few deletes; now and then the sender waits for all responses.
  task automatic test_random_traffic(input int count);
    cmd_t c;
    int pick;
    for (int i = 0; i < count; i++) begin
      c = cmd_of(OP_TICK, $urandom, $urandom, 4'($urandom_range(0, 15)));
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        c.opcode = OP_ADD;
        // Most adds get delays and periods of a few ticks so they fire soon.
        if ($urandom_range(0, 7) != 0) begin
          c.delay_ms  = $urandom_range(0, 80);
          c.period_ms = ($urandom_range(0, 5) == 0) ? $urandom_range(0, TICK_MS_DEF - 1)
                                                    : $urandom_range(TICK_MS_DEF, 60);
        end
      end else if (pick < 55) begin
        c.opcode = OP_TICK;
      end else if (pick < 95) begin
        c.opcode = OP_DISP;
      end else begin
        c.opcode = OP_DEL;
      end
      send_cmd(c);
      if ($urandom_range(0, 39) == 0) wait_responses();
    end
    wait_responses();
  endtask

  // Fill every remaining slot, then add past the end of the table.
  task automatic test_table_full();
    while (next_slot < MAX_TASKS_DEF) begin
      send_cmd(cmd_of(OP_ADD, $urandom_range(0, 40), $urandom_range(0, 40), 4'($urandom)));
    end
    send_cmd(cmd_of(OP_ADD, 32'd0, 32'd10, 4'h0));
    send_cmd(cmd_of(OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hF));
    repeat (4) send_cmd(cmd_of(OP_TICK, $urandom, $urandom, 4'($urandom)));
    send_cmd(cmd_of(OP_DISP, $urandom, $urandom, 4'($urandom)));
    wait_responses();
  endtask

  initial begin
    rst        = 1'b1;
    cmd_valid  = 1'b0;
    cmd        = '0;
    next_slot  = 0;
    burst_left = 0;
    stall_left = 0;
    for (int s = 0; s < MAX_TASKS_DEF; s++) clear_slot(s);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_add_extremes();
    test_dispatch_empty();
    test_tick_and_run();
    test_delete();
    test_random_traffic(195);
    test_table_full();

    // Drain, then let the block sit long enough to show any stray response.
    wait_responses();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d commands: %0d adds, %0d rejected on a full table, %0d deletes.",
             cmds_taken, adds_ok, adds_full, deletes_sent);
    $display("Checked %0d task runs; run count held at its ceiling on %0d ticks.",
             runs_due, ceiling_hits);
    if (error_count == 0 && due_responses.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d responses still owed", error_count, due_responses.size());
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
